// ----- rtl/chgw_pkg.sv -----
// Shared constants and types for the gift-wrap convex hull block.
// No dependencies; imported by every module of the block.
package chgw_pkg;

  localparam int MAX_RING = 64;                    // ring items, closing one included
  localparam int IDX_W    = $clog2(MAX_RING);      // point index width
  localparam int CNT_W    = $clog2(MAX_RING + 1);  // stored point count width
  localparam int COORD_W  = 32;                    // coordinate width
  localparam int DIF_W    = COORD_W + 1;           // coordinate difference width
  localparam int MAG_W    = COORD_W;               // |difference| always fits here
  localparam int PROD_W   = 2 * MAG_W;             // product magnitude width
  localparam int ENTRY_W  = 2 * COORD_W;           // one stored point: {x, y}

  localparam int MIN_POINTS = 3;

  // result status codes
  localparam logic [1:0] ST_HULL = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_MANY = 2'd2;

  // stage enables from the walk sequencer to the orientation datapath
  typedef struct packed {
    logic ld_dif;
    logic ld_abs;
    logic ld_m1;
    logic ld_m2;
  } chgw_stage_t;

endpackage

// ----- rtl/convex_hull_gift_wrap.sv -----
// Top level of the gift-wrap (Jarvis march) convex hull block.
// Depends on chgw_pkg, chgw_ram and chgw_orient.
//
// Usage:
//  - Input: one ring vertex per transaction, taken at a clock edge with start
//    high and busy low. in_last marks the closing vertex; its coordinates are
//    ignored. Up to MAX_RING-1 points are kept, extra ones flag an overflow.
//  - Output: each result is on the out_ ports for one cycle with out_valid
//    high. The receiver cannot stall; every result must be taken when shown.
//  - A closing transaction with an overflow gives one status-2 result, with
//    fewer than three points one status-1 result; both come in the next cycle
//    and the block stays free for the next ring.
//  - Otherwise busy rises and the hull walk runs: the hull vertices in order,
//    then a closing repeat of the first with out_end_of_run set.
// Rate:
//  - Loading: one vertex per cycle, stored through the point RAM write port.
//  - Walk: a leftmost search over all stored points, then per hull vertex
//    a test of every stored point, one at a time. Each test reads one point
//    from the RAM and runs through the orientation datapath, whose single
//    32x32 multiplier forms both cross-product terms in turn.
// Reset: synchronous, active low; clears the ring count, overflow flag,
// hull marks and the sequencer. The point RAM is not cleared.
module convex_hull_gift_wrap
  import chgw_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  input  logic                      in_last,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_hull_x,
  output logic signed [COORD_W-1:0] out_hull_y,
  output logic                      out_end_of_run,
  output logic [1:0]                out_status
);

  // one-hot walk sequencer
  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,  // loading vertices
    S_MIN  = 10'b00_0000_0010,  // leftmost point search
    S_EMIT = 10'b00_0000_0100,  // show current hull vertex, fetch first candidate
    S_CRD  = 10'b00_0000_1000,  // capture candidate, fetch point 0
    S_DIF  = 10'b00_0001_0000,
    S_ABS  = 10'b00_0010_0000,
    S_MUL1 = 10'b00_0100_0000,
    S_MUL2 = 10'b00_1000_0000,
    S_CMP  = 10'b01_0000_0000,  // take better candidate, fetch next point
    S_DEC  = 10'b10_0000_0000   // stop or advance
  } state_t;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]          ring_count_r, ring_count_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [MAX_RING-1:0]       on_hull_r, on_hull_nxt;
  logic [CNT_W-1:0]          k_r, k_nxt;            // hull vertices shown so far
  logic [IDX_W-1:0]          i_r, i_nxt;            // scan / read index
  logic [IDX_W-1:0]          didx_r;                // index of RAM data in hand
  logic                      dv_r;                  // RAM data valid in search
  logic [IDX_W-1:0]          cur_idx_r, cur_idx_nxt;
  logic [IDX_W-1:0]          cand_idx_r, cand_idx_nxt;
  logic [IDX_W-1:0]          min_idx_r, min_idx_nxt;
  logic signed [COORD_W-1:0] min_x_r, min_x_nxt, min_y_r, min_y_nxt;
  logic signed [COORD_W-1:0] cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic signed [COORD_W-1:0] cand_x_r, cand_x_nxt, cand_y_r, cand_y_nxt;
  logic signed [COORD_W-1:0] start_x_r, start_x_nxt, start_y_r, start_y_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0] out_x_r, out_x_nxt, out_y_r, out_y_nxt;
  logic                      out_eor_r, out_eor_nxt;
  logic [1:0]                out_st_r, out_st_nxt;

  logic                      accept;
  logic                      ram_we;
  logic [IDX_W-1:0]          rd_addr;
  logic [ENTRY_W-1:0]        rd_data;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic [IDX_W-1:0]          last_idx;
  logic [CNT_W-1:0]          cur_inc;
  logic [IDX_W-1:0]          cand_first;
  logic                      take_min;
  chgw_stage_t               stg;
  logic signed [COORD_W-1:0] q_x, q_y;
  logic                      ccw;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && !in_last && (ring_count_r < CNT_W'(MAX_RING - 1));

  assign rd_x = rd_data[ENTRY_W-1:COORD_W];
  assign rd_y = rd_data[COORD_W-1:0];

  assign last_idx   = IDX_W'(ring_count_r - 1'b1);
  assign cur_inc    = {1'b0, cur_idx_r} + 1'b1;
  assign cand_first = (cur_inc == ring_count_r) ? '0 : cur_inc[IDX_W-1:0];

  // leftmost: first data unconditionally, then strictly smaller x only
  assign take_min = dv_r && ((didx_r == '0) || (rd_x < min_x_r));

  assign stg.ld_dif = (state_r == S_DIF);
  assign stg.ld_abs = (state_r == S_ABS);
  assign stg.ld_m1  = (state_r == S_MUL1);
  assign stg.ld_m2  = (state_r == S_MUL2);

  chgw_ram u_ram (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ring_count_r[IDX_W-1:0]),
    .wr_data ({in_x, in_y}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  chgw_orient u_orient (
    .clk    (clk),
    .stg    (stg),
    .p_x    (cur_x_r),
    .p_y    (cur_y_r),
    .r_x    (cand_x_r),
    .r_y    (cand_y_r),
    .q_x_in (rd_x),
    .q_y_in (rd_y),
    .q_x    (q_x),
    .q_y    (q_y),
    .ccw    (ccw)
  );

  always_comb begin
    state_nxt      = state_r;
    ring_count_nxt = ring_count_r;
    ovf_nxt        = ovf_r;
    on_hull_nxt    = on_hull_r;
    k_nxt          = k_r;
    i_nxt          = i_r;
    cur_idx_nxt    = cur_idx_r;
    cand_idx_nxt   = cand_idx_r;
    min_idx_nxt    = min_idx_r;
    min_x_nxt      = min_x_r;
    min_y_nxt      = min_y_r;
    cur_x_nxt      = cur_x_r;
    cur_y_nxt      = cur_y_r;
    cand_x_nxt     = cand_x_r;
    cand_y_nxt     = cand_y_r;
    start_x_nxt    = start_x_r;
    start_y_nxt    = start_y_r;
    out_valid_nxt  = 1'b0;
    out_x_nxt      = out_x_r;
    out_y_nxt      = out_y_r;
    out_eor_nxt    = out_eor_r;
    out_st_nxt     = out_st_r;
    rd_addr        = i_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_last) begin
            if (ram_we) begin
              ring_count_nxt = ring_count_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (ovf_r || (ring_count_r < CNT_W'(MIN_POINTS))) begin
            // status transaction, ring dropped
            out_valid_nxt  = 1'b1;
            out_x_nxt      = '0;
            out_y_nxt      = '0;
            out_eor_nxt    = 1'b1;
            out_st_nxt     = ovf_r ? ST_MANY : ST_FEW;
            ring_count_nxt = '0;
            ovf_nxt        = 1'b0;
            on_hull_nxt    = '0;
          end else begin
            i_nxt     = '0;
            k_nxt     = '0;
            state_nxt = S_MIN;
          end
        end
      end

      S_MIN: begin
        i_nxt = i_r + 1'b1;
        if (take_min) begin
          min_idx_nxt = didx_r;
          min_x_nxt   = rd_x;
          min_y_nxt   = rd_y;
        end
        if (dv_r && (didx_r == last_idx)) begin
          cur_idx_nxt = take_min ? didx_r : min_idx_r;
          cur_x_nxt   = take_min ? rd_x : min_x_r;
          cur_y_nxt   = take_min ? rd_y : min_y_r;
          start_x_nxt = take_min ? rd_x : min_x_r;
          start_y_nxt = take_min ? rd_y : min_y_r;
          state_nxt   = S_EMIT;
        end
      end

      S_EMIT: begin
        on_hull_nxt[cur_idx_r] = 1'b1;
        out_valid_nxt = 1'b1;
        out_x_nxt     = cur_x_r;
        out_y_nxt     = cur_y_r;
        out_eor_nxt   = 1'b0;
        out_st_nxt    = ST_HULL;
        k_nxt         = k_r + 1'b1;
        cand_idx_nxt  = cand_first;
        rd_addr       = cand_first;
        state_nxt     = S_CRD;
      end

      S_CRD: begin
        cand_x_nxt = rd_x;
        cand_y_nxt = rd_y;
        i_nxt      = '0;
        rd_addr    = '0;
        state_nxt  = S_DIF;
      end

      S_DIF:  state_nxt = S_ABS;
      S_ABS:  state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_CMP;

      S_CMP: begin
        // testing the candidate against itself never reports a turn
        if (ccw) begin
          cand_idx_nxt = i_r;
          cand_x_nxt   = q_x;
          cand_y_nxt   = q_y;
        end
        if (i_r == last_idx) begin
          state_nxt = S_DEC;
        end else begin
          i_nxt     = i_r + 1'b1;
          rd_addr   = i_r + 1'b1;
          state_nxt = S_DIF;
        end
      end

      S_DEC: begin
        if (on_hull_r[cand_idx_r] || (k_r >= ring_count_r)) begin
          out_valid_nxt  = 1'b1;
          out_x_nxt      = start_x_r;
          out_y_nxt      = start_y_r;
          out_eor_nxt    = 1'b1;
          out_st_nxt     = ST_HULL;
          ring_count_nxt = '0;
          ovf_nxt        = 1'b0;
          on_hull_nxt    = '0;
          state_nxt      = S_IDLE;
        end else begin
          cur_idx_nxt = cand_idx_r;
          cur_x_nxt   = cand_x_r;
          cur_y_nxt   = cand_y_r;
          state_nxt   = S_EMIT;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      ring_count_r <= '0;
      ovf_r        <= 1'b0;
      on_hull_r    <= '0;
      k_r          <= '0;
      i_r          <= '0;
      dv_r         <= 1'b0;
      cur_idx_r    <= '0;
      cand_idx_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ring_count_r <= ring_count_nxt;
      ovf_r        <= ovf_nxt;
      on_hull_r    <= on_hull_nxt;
      k_r          <= k_nxt;
      i_r          <= i_nxt;
      dv_r         <= (state_r == S_MIN);
      cur_idx_r    <= cur_idx_nxt;
      cand_idx_r   <= cand_idx_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    didx_r    <= i_r;
    min_idx_r <= min_idx_nxt;
    min_x_r   <= min_x_nxt;
    min_y_r   <= min_y_nxt;
    cur_x_r   <= cur_x_nxt;
    cur_y_r   <= cur_y_nxt;
    cand_x_r  <= cand_x_nxt;
    cand_y_r  <= cand_y_nxt;
    start_x_r <= start_x_nxt;
    start_y_r <= start_y_nxt;
    out_x_r   <= out_x_nxt;
    out_y_r   <= out_y_nxt;
    out_eor_r <= out_eor_nxt;
    out_st_r  <= out_st_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_hull_x     = out_x_r;
  assign out_hull_y     = out_y_r;
  assign out_end_of_run = out_eor_r;
  assign out_status     = out_st_r;

  // status results carry no coordinates and always close the run
  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_HULL) |->
      out_end_of_run && (out_hull_x == '0) && (out_hull_y == '0))
    else $error("status result with coordinates or open run");

  // the run-closing transaction leaves the block free
  a_close_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_end_of_run |-> !busy)
    else $error("run closed while walk still active");

  // no more hull vertices than stored points
  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (k_r <= ring_count_r))
    else $error("hull vertex count exceeds ring size");

  // candidate always names a stored point during the scan
  a_cand_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIF) |-> ({1'b0, cand_idx_r} < ring_count_r))
    else $error("candidate index outside ring");

endmodule

// ----- rtl/chgw_ram.sv -----
// Point store: one write port, one read port, registered read data.
// Depends on chgw_pkg for depth and entry width.
module chgw_ram
  import chgw_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [MAX_RING];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/chgw_orient.sv -----
// Orientation test: is r strictly counterclockwise of q seen from p.
// Four registered stages, one shared 32x32 multiplier. Depends on chgw_pkg.
module chgw_orient
  import chgw_pkg::*;
(
  input  logic                      clk,
  input  chgw_stage_t               stg,
  input  logic signed [COORD_W-1:0] p_x,
  input  logic signed [COORD_W-1:0] p_y,
  input  logic signed [COORD_W-1:0] r_x,
  input  logic signed [COORD_W-1:0] r_y,
  input  logic signed [COORD_W-1:0] q_x_in,
  input  logic signed [COORD_W-1:0] q_y_in,
  output logic signed [COORD_W-1:0] q_x,
  output logic signed [COORD_W-1:0] q_y,
  output logic                      ccw
);

  logic [DIF_W-1:0]  a1_r, b1_r, a2_r, b2_r;
  logic [MAG_W-1:0]  ma1_r, mb1_r, ma2_r, mb2_r;
  logic              s1_r, s2_r;
  logic [PROD_W-1:0] m1_r, m2_r;
  logic [MAG_W-1:0]  mul_a, mul_b;
  logic [PROD_W-1:0] prod;
  logic              neg1, neg2;

  function automatic logic [MAG_W-1:0] mag_of(input logic [DIF_W-1:0] d);
    logic [DIF_W-1:0] nd;
    nd = -d;
    return d[DIF_W-1] ? nd[MAG_W-1:0] : d[MAG_W-1:0];
  endfunction

  // stage 1: differences, q latched for a later candidate update
  always_ff @(posedge clk) begin
    if (stg.ld_dif) begin
      q_x  <= q_x_in;
      q_y  <= q_y_in;
      a1_r <= {q_y_in[COORD_W-1], q_y_in} - {p_y[COORD_W-1], p_y};
      b1_r <= {r_x[COORD_W-1], r_x} - {q_x_in[COORD_W-1], q_x_in};
      a2_r <= {q_x_in[COORD_W-1], q_x_in} - {p_x[COORD_W-1], p_x};
      b2_r <= {r_y[COORD_W-1], r_y} - {q_y_in[COORD_W-1], q_y_in};
    end
  end

  // stage 2: sign and magnitude
  always_ff @(posedge clk) begin
    if (stg.ld_abs) begin
      ma1_r <= mag_of(a1_r);
      mb1_r <= mag_of(b1_r);
      ma2_r <= mag_of(a2_r);
      mb2_r <= mag_of(b2_r);
      s1_r  <= a1_r[DIF_W-1] ^ b1_r[DIF_W-1];
      s2_r  <= a2_r[DIF_W-1] ^ b2_r[DIF_W-1];
    end
  end

  // stages 3 and 4: both products through one multiplier
  // (zero-extended 32-bit magnitudes, so the product is 32x32 unsigned)
  assign mul_a = stg.ld_m2 ? ma2_r : ma1_r;
  assign mul_b = stg.ld_m2 ? mb2_r : mb1_r;
  assign prod  = PROD_W'(mul_a) * PROD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (stg.ld_m1) begin
      m1_r <= prod;
    end
    if (stg.ld_m2) begin
      m2_r <= prod;
    end
  end

  // first product < second product, compared in sign-magnitude form
  assign neg1 = s1_r && (m1_r != '0);
  assign neg2 = s2_r && (m2_r != '0);

  always_comb begin
    if (neg1 != neg2) begin
      ccw = neg1;
    end else if (!neg1) begin
      ccw = m1_r < m2_r;
    end else begin
      ccw = m1_r > m2_r;
    end
  end

endmodule
